/* rtl/vvo_pkg.sv */
// shared types, constants and the log(dz/dp) knot table for the vertical velocity core
// no dependencies; every other rtl file refers to this package by scoped names
package vvo_pkg;

  localparam int OMEGA_W      = 32;
  localparam int ALT_W        = 23;
  localparam int SPEED_W      = 48;

  localparam int KNOT_COUNT   = 70;
  localparam int KNOT_IDX_W   = 7;
  localparam int KNOT_W       = 29;
  localparam int KNOT_SCALE   = 10000000;

  localparam int LOG_W        = 32;
  localparam int EXP_ARG_W    = 28;
  localparam int LN2_Q24      = 11629080;
  localparam int EXP_BIAS     = 8;
  localparam int EXP_N_W      = 4;
  localparam int EXP_N_MAX    = 15;
  localparam int EXP_FRAC     = 30;
  localparam int R30_SHIFT    = 6;
  localparam int R30_W        = 30;
  localparam int TERM_W       = 31;
  localparam int SUM_W        = 32;
  localparam int TAYLOR_TERMS = 12;
  localparam int EXP_W        = SUM_W + EXP_N_MAX - EXP_BIAS;
  localparam int E10_SHIFT    = 6;
  localparam int E10_ROUND    = 32;
  localparam int E10_W        = EXP_W + 4 - E10_SHIFT;
  localparam int SCALE_FRAC   = 24;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_RANGE   = 2'd2
  } vvo_status_t;

  // control and pass-along data that rides beside each item
  typedef struct packed {
    logic                vld;
    vvo_status_t         status;
    logic                oneg;
    logic [OMEGA_W-1:0]  omag;
  } vvo_side_t;

  typedef struct packed {
    logic                vld;
    vvo_status_t         status;
    logic [SPEED_W-1:0]  speed;
  } vvo_result_t;

  // log(dz/dp) knots in units of 1e-7, 1 km apart from 0 km
  localparam int KNOT_E7 [KNOT_COUNT] = '{
    -47962600, -46879000, -45883600, -44864300, -43820000, -42749300,
    -41650900, -40523400, -39365100, -38174400, -36949200, -35603600,
    -34088900, -32512000, -30935100, -29358200, -27781300, -26204500,
    -24627600, -23050700, -21460700, -19851700, -18240600, -16636800,
    -15040300, -13451100, -11868800, -10293900, -8725890, -7164750,
    -5610580, -4063190, -2500380, -911927, 673624, 2240370,
    3788720, 5319110, 6832100, 8327890, 9806900, 11269600,
    12716300, 14147300, 15563000, 16963600, 18349700, 19692200,
    20976800, 22239000, 23501300, 24734700, 25923100, 27101200,
    28291800, 29495200, 30711800, 31941600, 33185200, 34442700,
    35714500, 37001000, 38302400, 39619100, 40951400, 42300000,
    43664800, 45046500, 46445700, 47666700
  };

  typedef logic signed [KNOT_W-1:0] vvo_knot_tab_t [KNOT_COUNT];

  // knots in q.24, magnitude rounded half away from zero
  function automatic vvo_knot_tab_t build_knots();
    vvo_knot_tab_t tab;
    longint        v;
    longint        m;
    longint        q;
    for (int i = 0; i < KNOT_COUNT; i++) begin
      v = longint'(KNOT_E7[i]);
      m = (v < 0) ? -v : v;
      q = ((m << 24) + longint'(KNOT_SCALE / 2)) / KNOT_SCALE;
      tab[i] = KNOT_W'((v < 0) ? -q : q);
    end
    return tab;
  endfunction

  localparam vvo_knot_tab_t KNOT_Q24 = build_knots();

endpackage

/* rtl/vertical_velocity_from_omega_core.sv */
// top level of the vertical velocity core: pipeline of interpolation, exponent
// and scaling units plus the output register and skid stage; uses vvo_pkg
//
// Turns an omega sample (Pa/s, signed Q11.20) and a pressure altitude (km,
// unsigned Q7.16) into dz/dt in m/s (signed Q27.20) with a status code. The
// altitude indexes a fixed 70-knot table of log(dz/dp) at 1 km steps; the log
// is interpolated linearly, exponentiated (ln2 range reduction and a 12-term
// Taylor series), scaled to m/Pa, negated and multiplied by omega. Status is
// missing (speed 0) when either valid flag in tuser is low, and out of range
// (speed 0) when the altitude is zero or above the top knot, TABLE_POINTS-1 km.
// Every input item gives exactly one result item, in order. An item can be
// accepted every cycle while the skid entry is empty; the path from input handshake
// to the earliest result handshake on the master side runs through 3 interpolation
// stages, 27 exponent stages dominated by one multiply stage and one divide stage per
// series term, 3 scaling stages and the output register. The whole pipeline advances
// together; a one-entry skid stage behind the output register keeps
// s_axis_tready a registered signal, so it drops only once the skid entry is
// occupied by a result the downstream side has not yet taken.
module vertical_velocity_from_omega_core #(
  parameter int TABLE_POINTS  = 70,
  parameter int ALT_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // [31:0] omega_sample, [54:32] altitude_km, [55] zero
  input  logic [1:0]  s_axis_tuser,   // [0] omega_valid, [1] altitude_valid
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [47:0] vertical_speed
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int OW = vvo_pkg::OMEGA_W;
  localparam int AW = vvo_pkg::ALT_W;

  // pipeline advance: held only while the skid entry is full
  logic                                adv;
  vvo_pkg::vvo_side_t                  interp_side;
  logic [vvo_pkg::EXP_ARG_W-1:0]       interp_arg;
  vvo_pkg::vvo_side_t                  exp_side;
  logic [vvo_pkg::E10_W-1:0]           exp_e10;
  vvo_pkg::vvo_result_t                pipe_res;

  vvo_log_interp #(
    .TABLE_POINTS  (TABLE_POINTS),
    .ALT_FRAC_BITS (ALT_FRAC_BITS)
  ) u_interp (
    .clk            (clk),
    .rst            (rst),
    .en             (adv),
    .in_vld         (s_axis_tvalid),
    .omega_sample   (s_axis_tdata[OW-1:0]),
    .omega_valid    (s_axis_tuser[0]),
    .altitude_km    (s_axis_tdata[OW+AW-1:OW]),
    .altitude_valid (s_axis_tuser[1]),
    .side_out       (interp_side),
    .arg_out        (interp_arg)
  );

  vvo_exp u_exp (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .side_in  (interp_side),
    .arg_in   (interp_arg),
    .side_out (exp_side),
    .e10_out  (exp_e10)
  );

  vvo_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .side_in (exp_side),
    .e10_in  (exp_e10),
    .res_out (pipe_res)
  );

  // output register and skid entry
  logic                                out_vld;
  vvo_pkg::vvo_status_t                out_status;
  logic [vvo_pkg::SPEED_W-1:0]         out_speed;
  logic                                skid_vld;
  vvo_pkg::vvo_status_t                skid_status;
  logic [vvo_pkg::SPEED_W-1:0]         skid_speed;
  logic                                out_free;

  assign out_free = !out_vld || m_axis_tready;
  assign adv      = !skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (skid_vld) begin
        // pipeline frozen; drain skid once the output moves
        if (out_free) begin
          out_vld  <= 1'b1;
          skid_vld <= 1'b0;
        end
      end else if (out_free) begin
        out_vld <= pipe_res.vld;
      end else if (pipe_res.vld) begin
        skid_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (out_free) begin
        out_status <= skid_status;
        out_speed  <= skid_speed;
      end
    end else if (out_free) begin
      out_status <= pipe_res.status;
      out_speed  <= pipe_res.speed;
    end else begin
      skid_status <= pipe_res.status;
      skid_speed  <= pipe_res.speed;
    end
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = out_speed;
  assign m_axis_tuser  = out_status;

  // skid entry only fills behind a held output item
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid entry valid with empty output register");

  // a stalled output keeps the skid entry
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_vld && out_vld && !m_axis_tready |=> skid_vld)
    else $error("skid entry dropped while output stalled");

  // missing or out-of-range items carry zero speed
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_status != vvo_pkg::ST_OK |-> out_speed == '0)
    else $error("nonzero speed on a faulted item");

  // no input taken while the skid entry is occupied
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    $past(skid_vld) && !$past(rst) |-> !$past(s_axis_tready))
    else $error("input accepted with skid entry full");

endmodule

/* rtl/vvo_log_interp.sv */
// front stages: input decode and range check, knot lookup and slope product,
// log-domain interpolation and biasing of the exponent argument; uses vvo_pkg
module vvo_log_interp #(
  parameter int TABLE_POINTS  = 70,
  parameter int ALT_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic [vvo_pkg::OMEGA_W-1:0]         omega_sample,
  input  logic                                omega_valid,
  input  logic [vvo_pkg::ALT_W-1:0]           altitude_km,
  input  logic                                altitude_valid,
  output vvo_pkg::vvo_side_t                  side_out,
  output logic [vvo_pkg::EXP_ARG_W-1:0]       arg_out
);

  localparam int PTS       = (TABLE_POINTS > vvo_pkg::KNOT_COUNT) ? vvo_pkg::KNOT_COUNT :
                             ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
  localparam int TOP       = PTS - 1;
  localparam int FRAC_W    = ALT_FRAC_BITS + 1;
  localparam int ALT_EXT_W = vvo_pkg::ALT_W + ALT_FRAC_BITS;
  localparam int DMAG_W    = vvo_pkg::KNOT_W + 1;
  localparam int PROD_W    = DMAG_W + FRAC_W;
  localparam int LOG_W     = vvo_pkg::LOG_W;
  localparam logic [ALT_EXT_W-1:0] TOP_ALT = ALT_EXT_W'(TOP) << ALT_FRAC_BITS;
  localparam logic signed [LOG_W-1:0] EXP_OFFSET =
    LOG_W'(vvo_pkg::EXP_BIAS * vvo_pkg::LN2_Q24);

  // stage 1: decode
  logic [ALT_EXT_W-1:0]                alt_ext;
  logic [ALT_EXT_W-1:0]                idx_raw;
  vvo_pkg::vvo_side_t                  side1_next;
  logic [vvo_pkg::KNOT_IDX_W-1:0]      idx_next;
  logic [FRAC_W-1:0]                   frac_next;
  vvo_pkg::vvo_side_t                  s1_side;
  logic [vvo_pkg::KNOT_IDX_W-1:0]      s1_idx;
  logic [FRAC_W-1:0]                   s1_frac;

  always_comb begin
    alt_ext         = ALT_EXT_W'(altitude_km);
    idx_raw         = alt_ext >> ALT_FRAC_BITS;
    side1_next.vld  = in_vld;
    side1_next.oneg = omega_sample[vvo_pkg::OMEGA_W-1];
    side1_next.omag = side1_next.oneg ? (vvo_pkg::OMEGA_W'(0) - omega_sample) : omega_sample;
    priority if (!omega_valid || !altitude_valid) begin
      side1_next.status = vvo_pkg::ST_MISSING;
    end else if (alt_ext == '0 || alt_ext > TOP_ALT) begin
      side1_next.status = vvo_pkg::ST_RANGE;
    end else begin
      side1_next.status = vvo_pkg::ST_OK;
    end
    // at the top knot the last segment is used with full fraction
    if (idx_raw >= ALT_EXT_W'(TOP)) begin
      idx_next  = vvo_pkg::KNOT_IDX_W'(TOP - 1);
      frac_next = FRAC_W'(1) << ALT_FRAC_BITS;
    end else begin
      idx_next  = idx_raw[vvo_pkg::KNOT_IDX_W-1:0];
      frac_next = {1'b0, alt_ext[ALT_FRAC_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side.vld <= 1'b0;
    end else if (en) begin
      s1_side <= side1_next;
      s1_idx  <= idx_next;
      s1_frac <= frac_next;
    end
  end

  // stage 2: knot pair and |slope| * fraction
  logic signed [vvo_pkg::KNOT_W-1:0]   l0;
  logic signed [vvo_pkg::KNOT_W-1:0]   l1;
  logic signed [DMAG_W-1:0]            d;
  logic [DMAG_W-1:0]                   dmag;
  logic [PROD_W-1:0]                   prod_next;
  vvo_pkg::vvo_side_t                  s2_side;
  logic signed [vvo_pkg::KNOT_W-1:0]   s2_l0;
  logic                                s2_dneg;
  logic [PROD_W-1:0]                   s2_prod;

  always_comb begin
    l0        = vvo_pkg::KNOT_Q24[s1_idx];
    l1        = vvo_pkg::KNOT_Q24[s1_idx + 1'b1];
    d         = DMAG_W'(l1) - DMAG_W'(l0);
    dmag      = d[DMAG_W-1] ? DMAG_W'(-d) : DMAG_W'(d);
    prod_next = PROD_W'(dmag) * PROD_W'(s1_frac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side.vld <= 1'b0;
    end else if (en) begin
      s2_side <= s1_side;
      s2_l0   <= l0;
      s2_dneg <= d[DMAG_W-1];
      s2_prod <= prod_next;
    end
  end

  // stage 3: rounded step, log value, biased exponent argument
  logic [DMAG_W-1:0]                   q;
  logic signed [LOG_W-1:0]             l0_ext;
  logic signed [LOG_W-1:0]             q_ext;
  logic signed [LOG_W-1:0]             lq;
  logic signed [LOG_W-1:0]             lp;
  logic [vvo_pkg::EXP_ARG_W-1:0]       arg_next;

  always_comb begin
    q        = DMAG_W'((s2_prod + (PROD_W'(1) << (ALT_FRAC_BITS - 1))) >> ALT_FRAC_BITS);
    l0_ext   = LOG_W'(s2_l0);
    q_ext    = $signed(LOG_W'(q));
    lq       = s2_dneg ? (l0_ext - q_ext) : (l0_ext + q_ext);
    lp       = lq + EXP_OFFSET;
    arg_next = lp[LOG_W-1] ? '0 : lp[vvo_pkg::EXP_ARG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.vld <= 1'b0;
    end else if (en) begin
      side_out <= s2_side;
      arg_out  <= arg_next;
    end
  end

endmodule

/* rtl/vvo_exp.sv */
// exponent unit: range reduction by ln2, 12-term taylor series one term per
// multiply/divide stage pair, power-of-two scaling and the x10 q.24 factor; uses vvo_pkg
module vvo_exp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  vvo_pkg::vvo_side_t                  side_in,
  input  logic [vvo_pkg::EXP_ARG_W-1:0]       arg_in,
  output vvo_pkg::vvo_side_t                  side_out,
  output logic [vvo_pkg::E10_W-1:0]           e10_out
);

  localparam int T      = vvo_pkg::TAYLOR_TERMS;
  localparam int TERM_W = vvo_pkg::TERM_W;
  localparam int SUM_W  = vvo_pkg::SUM_W;
  localparam int R30_W  = vvo_pkg::R30_W;
  localparam int N_W    = vvo_pkg::EXP_N_W;
  localparam int MUL_W  = TERM_W + R30_W;
  localparam int EXP_W  = vvo_pkg::EXP_W;
  localparam int X10_W  = EXP_W + 4;
  localparam int NUM_W  = vvo_pkg::EXP_FRAC;
  localparam int RCP_W  = 31;
  localparam int QP_W   = NUM_W + RCP_W;

  // reduction: n = arg / ln2 by threshold compares, r = arg - n*ln2
  logic [N_W-1:0]                      n_next;
  logic [vvo_pkg::EXP_ARG_W-1:0]       base;
  logic [vvo_pkg::EXP_ARG_W-1:0]       rem;

  always_comb begin
    n_next = '0;
    base   = '0;
    for (int k = 1; k <= vvo_pkg::EXP_N_MAX; k++) begin
      if (arg_in >= vvo_pkg::EXP_ARG_W'(k * vvo_pkg::LN2_Q24)) begin
        n_next = N_W'(k);
        base   = vvo_pkg::EXP_ARG_W'(k * vvo_pkg::LN2_Q24);
      end
    end
    rem = arg_in - base;
  end

  // d_* index k holds the state after term k; index 0 is the reduction stage
  vvo_pkg::vvo_side_t                  d_side [T+1];
  logic [N_W-1:0]                      d_n    [T+1];
  logic [R30_W-1:0]                    d_r30  [T+1];
  logic [TERM_W-1:0]                   d_term [T+1];
  logic [SUM_W-1:0]                    d_sum  [T+1];
  vvo_pkg::vvo_side_t                  m_side [1:T];
  logic [N_W-1:0]                      m_n    [1:T];
  logic [R30_W-1:0]                    m_r30  [1:T];
  logic [SUM_W-1:0]                    m_sum  [1:T];
  logic [MUL_W-1:0]                    m_prod [1:T];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_side[0].vld <= 1'b0;
    end else if (en) begin
      d_side[0] <= side_in;
      d_n[0]    <= n_next;
      d_r30[0]  <= R30_W'(rem) << vvo_pkg::R30_SHIFT;
      d_term[0] <= TERM_W'(1) << vvo_pkg::EXP_FRAC;
      d_sum[0]  <= SUM_W'(1) << vvo_pkg::EXP_FRAC;
    end
  end

  for (genvar k = 1; k <= T; k++) begin : g_term
    // divide by k as a reciprocal multiply, exact for numerators below 2^30
    localparam int RCP_SH = vvo_pkg::EXP_FRAC + $clog2(k);
    localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((64'(1) << RCP_SH) + 64'(k - 1)) / 64'(k));
    logic [NUM_W-1:0]  num;
    logic [QP_W-1:0]   qprod;
    logic [TERM_W-1:0] quot;

    always_ff @(posedge clk) begin
      if (rst) begin
        m_side[k].vld <= 1'b0;
      end else if (en) begin
        m_side[k] <= d_side[k-1];
        m_n[k]    <= d_n[k-1];
        m_r30[k]  <= d_r30[k-1];
        m_sum[k]  <= d_sum[k-1];
        m_prod[k] <= MUL_W'(d_term[k-1]) * MUL_W'(d_r30[k-1]);
      end
    end

    assign num   = NUM_W'(m_prod[k] >> vvo_pkg::EXP_FRAC);
    assign qprod = QP_W'(num) * QP_W'(RCP);
    assign quot  = TERM_W'(qprod >> RCP_SH);

    always_ff @(posedge clk) begin
      if (rst) begin
        d_side[k].vld <= 1'b0;
      end else if (en) begin
        d_side[k] <= m_side[k];
        d_n[k]    <= m_n[k];
        d_r30[k]  <= m_r30[k];
        d_term[k] <= quot;
        d_sum[k]  <= m_sum[k] + SUM_W'(quot);
      end
    end
  end

  // scale by 2^(n-8)
  logic [EXP_W-1:0]                    e_next;
  vvo_pkg::vvo_side_t                  sh_side;
  logic [EXP_W-1:0]                    sh_e;

  always_comb begin
    if (d_n[T] >= N_W'(vvo_pkg::EXP_BIAS)) begin
      e_next = EXP_W'(d_sum[T]) << (d_n[T] - N_W'(vvo_pkg::EXP_BIAS));
    end else begin
      e_next = EXP_W'(d_sum[T] >> (N_W'(vvo_pkg::EXP_BIAS) - d_n[T]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_side.vld <= 1'b0;
    end else if (en) begin
      sh_side <= d_side[T];
      sh_e    <= e_next;
    end
  end

  // 10*exp in q.24, rounded
  logic [X10_W-1:0]                    e_x10;

  always_comb begin
    e_x10 = (X10_W'(sh_e) << 3) + (X10_W'(sh_e) << 1) + X10_W'(vvo_pkg::E10_ROUND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.vld <= 1'b0;
    end else if (en) begin
      side_out <= sh_side;
      e10_out  <= e_x10[X10_W-1:vvo_pkg::E10_SHIFT];
    end
  end

endmodule

/* rtl/vvo_scale.sv */
// back stages: omega times dz/dp as four registered partial products, rounded
// sum, then sign, saturation and status masking; uses vvo_pkg
module vvo_scale (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  vvo_pkg::vvo_side_t                  side_in,
  input  logic [vvo_pkg::E10_W-1:0]           e10_in,
  output vvo_pkg::vvo_result_t                res_out
);

  localparam int OM_LO_W = vvo_pkg::OMEGA_W / 2;
  localparam int OM_HI_W = vvo_pkg::OMEGA_W - OM_LO_W;
  localparam int E_LO_W  = 19;
  localparam int E_HI_W  = vvo_pkg::E10_W - E_LO_W;
  localparam int TOT_W   = vvo_pkg::OMEGA_W + vvo_pkg::E10_W;
  localparam int RES_W   = TOT_W - vvo_pkg::SCALE_FRAC;
  localparam int SW      = vvo_pkg::SPEED_W;
  localparam logic [SW:0] POS_MAX = (SW + 1)'((64'(1) << (SW - 1)) - 64'(1));
  localparam logic [SW:0] NEG_MAX = (SW + 1)'(64'(1) << (SW - 1));

  // partial products
  vvo_pkg::vvo_side_t                  p_side;
  logic [OM_LO_W+E_LO_W-1:0]           pp_ll;
  logic [OM_LO_W+E_HI_W-1:0]           pp_lh;
  logic [OM_HI_W+E_LO_W-1:0]           pp_hl;
  logic [OM_HI_W+E_HI_W-1:0]           pp_hh;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_side.vld <= 1'b0;
    end else if (en) begin
      p_side <= side_in;
      pp_ll  <= side_in.omag[OM_LO_W-1:0] * e10_in[E_LO_W-1:0];
      pp_lh  <= side_in.omag[OM_LO_W-1:0] * e10_in[vvo_pkg::E10_W-1:E_LO_W];
      pp_hl  <= side_in.omag[vvo_pkg::OMEGA_W-1:OM_LO_W] * e10_in[E_LO_W-1:0];
      pp_hh  <= side_in.omag[vvo_pkg::OMEGA_W-1:OM_LO_W] * e10_in[vvo_pkg::E10_W-1:E_LO_W];
    end
  end

  // rounded magnitude, q.20
  logic [TOT_W-1:0]                    total;
  vvo_pkg::vvo_side_t                  s_side;
  logic [RES_W-1:0]                    s_res;

  always_comb begin
    total = (TOT_W'(pp_hh) << (OM_LO_W + E_LO_W)) + (TOT_W'(pp_hl) << OM_LO_W)
          + (TOT_W'(pp_lh) << E_LO_W) + TOT_W'(pp_ll)
          + (TOT_W'(1) << (vvo_pkg::SCALE_FRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_side.vld <= 1'b0;
    end else if (en) begin
      s_side <= p_side;
      s_res  <= total[TOT_W-1:vvo_pkg::SCALE_FRAC];
    end
  end

  // sign (dz/dp is negative), saturation, status
  logic [SW:0]                         res_ext;
  logic [SW:0]                         lim;
  logic [SW:0]                         mag;
  logic [SW:0]                         neg_mag;
  vvo_pkg::vvo_result_t                res_next;

  always_comb begin
    res_ext         = (SW + 1)'(s_res);
    lim             = s_side.oneg ? POS_MAX : NEG_MAX;
    mag             = (res_ext > lim) ? lim : res_ext;
    neg_mag         = (SW + 1)'(0) - mag;
    res_next.vld    = s_side.vld;
    res_next.status = s_side.status;
    if (s_side.status != vvo_pkg::ST_OK) begin
      res_next.speed = '0;
    end else if (s_side.oneg) begin
      res_next.speed = mag[SW-1:0];
    end else begin
      res_next.speed = neg_mag[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.vld <= 1'b0;
    end else if (en) begin
      res_out <= res_next;
    end
  end

endmodule
